// ===== design/bpff_pkg.sv =====
`default_nettype none
package bpff_pkg;

  // Field widths
  localparam int SIZE_W   = 20;
  localparam int HANDLE_W = 32;
  localparam int BYTES_W  = 24;
  localparam int OUTC_W   = 3;

  // Default pool depth and budget after reset
  localparam int POOL_ENTRIES_DEF = 16;
  localparam logic [BYTES_W-1:0] CACHE_LIMIT_RST = 24'd1048576;

  // Operation codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUTC_REUSE    = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_MISS     = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_CACHED   = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_RELEASED = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_INVALID  = 3'd4;

  // Per-cell load controls
  typedef struct packed {
    logic take_next;
    logic take_new;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/bpff_cell.sv =====
`default_nettype none
module bpff_cell (
  input  wire logic                       clk,
  input  wire bpff_pkg::cell_ctl_t        ctl,
  input  wire logic [bpff_pkg::HANDLE_W-1:0] nxt_handle,
  input  wire logic [bpff_pkg::SIZE_W-1:0]   nxt_length,
  input  wire logic [bpff_pkg::HANDLE_W-1:0] new_handle,
  input  wire logic [bpff_pkg::SIZE_W-1:0]   new_length,
  output logic      [bpff_pkg::HANDLE_W-1:0] handle,
  output logic      [bpff_pkg::SIZE_W-1:0]   length
);
  import bpff_pkg::*;

  // Load an appended descriptor, or take the neighbor's on rotate or compact
  always_ff @(posedge clk) begin
    if (ctl.take_new) begin
      handle <= new_handle;
      length <= new_length;
    end else if (ctl.take_next) begin
      handle <= nxt_handle;
      length <= nxt_length;
    end
  end

endmodule
`default_nettype wire

// ===== design/buffer_pool_first_fit_unit.sv =====
`default_nettype none
// First-fit recycling pool of buffer descriptors held in a row of
// POOL_ENTRIES cells, oldest at cell 0. A free (tuser = 1) is decided and
// appended in the cycle it is accepted, so its result appears in the
// next cycle. An allocate (tuser = 0) rotates the whole row once through
// cell 0, one cell per cycle, to find the oldest entry that fits, then
// closes the gap once the output register is free, registering its result
// as it does so. A new request is accepted only while the block is idle
// and the output register is empty or being drained in the same cycle, so a
// stalled consumer also holds off further requests. cache_limit is written
// through the cfg channel, which is always ready.
module buffer_pool_first_fit_unit #(
  parameter int POOL_ENTRIES = bpff_pkg::POOL_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: cache_limit
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data,
  // Requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // size[19:0], handle[51:20], zero pad
  input  wire logic        s_tuser,   // cmd
  // Results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [79:0] m_tdata,   // out_handle[31:0], out_length[51:32],
                                      // cached_bytes[75:52], zero pad
  output logic      [2:0]  m_tuser    // outcome
);
  import bpff_pkg::*;

  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(POOL_ENTRIES - 1);
  localparam logic [CW-1:0] FULL = CW'(POOL_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       count;
  logic [BYTES_W-1:0]  total;
  logic [BYTES_W-1:0]  limit;
  logic [CW-1:0]       step;
  logic [CW-1:0]       hit;
  logic                found;
  logic [SIZE_W-1:0]   req_size;
  logic [HANDLE_W-1:0] cap_handle;
  logic [SIZE_W-1:0]   cap_length;

  logic [OUTC_W-1:0]   o_outcome;
  logic [HANDLE_W-1:0] o_handle;
  logic [SIZE_W-1:0]   o_length;
  logic [BYTES_W-1:0]  o_bytes;

  logic [HANDLE_W-1:0] cell_handle [POOL_ENTRIES];
  logic [SIZE_W-1:0]   cell_length [POOL_ENTRIES];
  cell_ctl_t           cell_ctl    [POOL_ENTRIES];

  logic                in_cmd;
  logic [SIZE_W-1:0]   in_size;
  logic [HANDLE_W-1:0] in_handle;
  logic                in_xfer;
  logic                out_free;
  logic [BYTES_W:0]    budget_sum;
  logic                over_budget;
  logic                pool_full;
  logic                free_ok;
  logic                scan_hit;
  logic                finish;
  logic                compact;
  logic                rotate;
  logic [BYTES_W-1:0]  cap_len_w;
  logic [BYTES_W-1:0]  reuse_total;

  assign in_cmd    = s_tuser;
  assign in_size   = s_tdata[19:0];
  assign in_handle = s_tdata[51:20];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_xfer  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Budget check without overflow
  assign budget_sum  = {1'b0, total} + (BYTES_W + 1)'(in_size);
  assign over_budget = budget_sum >= {1'b0, limit};
  assign pool_full   = (count == FULL);
  assign free_ok     = in_xfer && (in_cmd == CMD_FREE) && (in_handle != '0)
                       && !over_budget && !pool_full;

  // First fit: the head cell holds original entry number step
  assign rotate   = (state == ST_SCAN);
  assign scan_hit = rotate && !found && (step < count) && (cell_length[0] >= req_size);
  assign finish   = (state == ST_DONE) && out_free;
  assign compact  = finish && found;

  // Lower the total on reuse, floored at zero
  assign cap_len_w   = BYTES_W'(cap_length);
  assign reuse_total = (total >= cap_len_w) ? (total - cap_len_w) : '0;

  // Row of cells: each takes from its right neighbor, the last from the head
  for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
    localparam int NXT = (i == POOL_ENTRIES - 1) ? 0 : i + 1;
    assign cell_ctl[i].take_next = rotate || (compact && (CW'(i) >= hit));
    assign cell_ctl[i].take_new  = free_ok && (CW'(i) == count);
    bpff_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .nxt_handle (cell_handle[NXT]),
      .nxt_length (cell_length[NXT]),
      .new_handle (in_handle),
      .new_length (in_size),
      .handle     (cell_handle[i]),
      .length     (cell_length[i])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      total    <= '0;
      limit    <= CACHE_LIMIT_RST;
      step     <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      // Raise valid when a result is loaded, drop it after the transfer
      if ((in_xfer && (in_cmd == CMD_FREE)) || finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_cmd == CMD_FREE) begin
              if (free_ok) begin
                count <= count + 1'b1;
                total <= total + BYTES_W'(in_size);
              end
            end else begin
              step  <= '0;
              found <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            found <= 1'b1;
          end
          step <= step + 1'b1;
          if (step == LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (finish) begin
            state <= ST_IDLE;
            if (found) begin
              count <= count - 1'b1;
              total <= reuse_total;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_size <= in_size;
    end
    if (scan_hit) begin
      hit        <= step;
      cap_handle <= cell_handle[0];
      cap_length <= cell_length[0];
    end
    if (in_xfer && (in_cmd == CMD_FREE)) begin
      o_handle <= '0;
      o_length <= '0;
      if (in_handle == '0) begin
        o_outcome <= OUTC_INVALID;
        o_bytes   <= total;
      end else if (free_ok) begin
        o_outcome <= OUTC_CACHED;
        o_bytes   <= total + BYTES_W'(in_size);
      end else begin
        o_outcome <= OUTC_RELEASED;
        o_bytes   <= total;
      end
    end else if (finish) begin
      if (found) begin
        o_outcome <= OUTC_REUSE;
        o_handle  <= cap_handle;
        o_length  <= cap_length;
        o_bytes   <= reuse_total;
      end else begin
        o_outcome <= OUTC_MISS;
        o_handle  <= '0;
        o_length  <= req_size;
        o_bytes   <= total;
      end
    end
  end

  assign m_tdata = {4'b0, o_bytes, o_length, o_handle};
  assign m_tuser = o_outcome;

`ifndef SYNTHESIS
  // Fill level never passes the pool depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("pool count above depth");

  // The fill level holds still while a search rotates the row
  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> $stable(count))
    else $error("pool count changed during search");

  // A null free reports invalid on the next cycle
  a_null_free: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_cmd == CMD_FREE) && (in_handle == '0))
      |=> (m_tvalid && (m_tuser == OUTC_INVALID)))
    else $error("null free not reported");

  // A cached free keeps the total below the budget
  a_cached_budget: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == OUTC_CACHED)) |-> (o_bytes < limit))
    else $error("cached total reached budget");
`endif

endmodule
`default_nettype wire

// ===== sim/pool_result_checker.sv =====
`timescale 1ns / 1ps
module pool_result_checker #(
  parameter int POOL_ENTRIES = bpff_pkg::POOL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // size[19:0], handle[51:20], zero pad
  input  logic        s_tuser,   // cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // out_handle[31:0], out_length[51:32],
                                 // cached_bytes[75:52], zero pad
  input  logic [2:0]  m_tuser,   // outcome
  output int          mismatch_count,
  output int          pending_results
);
  import bpff_pkg::*;

  typedef struct packed {
    logic [OUTC_W-1:0]   outcome;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   length;
    logic [BYTES_W-1:0]  total;
  } pool_result_t;

  // Shadow copy of the pool
  logic [HANDLE_W-1:0] pool_handle [POOL_ENTRIES];
  logic [SIZE_W-1:0]   pool_length [POOL_ENTRIES];
  int                  pool_count;
  logic [BYTES_W-1:0]  pool_total;
  logic [BYTES_W-1:0]  pool_limit;

  pool_result_t expected_results [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Apply one request to the shadow pool and return the result it causes
  task automatic predict_pool_op(input logic cmd, input logic [SIZE_W-1:0] size,
                                 input logic [HANDLE_W-1:0] handle,
                                 output pool_result_t res);
    int hit;
    logic [BYTES_W:0] budget_sum;
    res = '0;
    hit = -1;
    if (cmd == CMD_ALLOC) begin
      // first fit: oldest entry long enough
      for (int i = 0; i < pool_count; i++) begin
        if (hit < 0 && pool_length[i] >= size) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        res.outcome = OUTC_REUSE;
        res.handle  = pool_handle[hit];
        res.length  = pool_length[hit];
        pool_total  = (pool_total >= BYTES_W'(pool_length[hit])) ?
                      pool_total - BYTES_W'(pool_length[hit]) : '0;
        // close the gap
        for (int i = hit; i < pool_count - 1; i++) begin
          pool_handle[i] = pool_handle[i+1];
          pool_length[i] = pool_length[i+1];
        end
        pool_count--;
      end else begin
        res.outcome = OUTC_MISS;
        res.length  = size;
      end
    end else begin
      budget_sum = (BYTES_W+1)'(size) + (BYTES_W+1)'(pool_total);
      if (handle == '0) begin
        res.outcome = OUTC_INVALID;
      end else if (budget_sum >= (BYTES_W+1)'(pool_limit) || pool_count >= POOL_ENTRIES) begin
        res.outcome = OUTC_RELEASED;
      end else begin
        pool_handle[pool_count] = handle;
        pool_length[pool_count] = size;
        pool_count++;
        pool_total  = pool_total + BYTES_W'(size);
        res.outcome = OUTC_CACHED;
      end
    end
    res.total = pool_total;
  endtask

  // Track transfers on all three channels
  always @(posedge clk) begin
    pool_result_t want;
    pool_result_t got;
    if (rst) begin
      pool_count = 0;
      pool_total = '0;
      pool_limit = CACHE_LIMIT_RST;
      expected_results.delete();
    end else begin
      // compare results first: a result never belongs to a request of the same edge
      if (m_tvalid && m_tready) begin
        got.outcome = m_tuser;
        got.handle  = m_tdata[31:0];
        got.length  = m_tdata[51:32];
        got.total   = m_tdata[75:52];
        if (expected_results.size() == 0) begin
          report_mismatch("result with none expected, outcome", 32'(got.outcome), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.outcome !== want.outcome)
            report_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
          if (got.handle !== want.handle)
            report_mismatch("out_handle", got.handle, want.handle);
          if (got.length !== want.length)
            report_mismatch("out_length", 32'(got.length), 32'(want.length));
          if (got.total !== want.total)
            report_mismatch("cached_bytes", 32'(got.total), 32'(want.total));
        end
      end
      if (cfg_valid && cfg_ready) begin
        pool_limit = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        predict_pool_op(s_tuser, s_tdata[19:0], s_tdata[51:20], want);
        expected_results = {expected_results, want};
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== sim/buffer_pool_first_fit_unit_tb.sv =====
`timescale 1ns / 1ps
module buffer_pool_first_fit_unit_tb;
  import bpff_pkg::*;

  localparam int POOL_ENTRIES = POOL_ENTRIES_DEF;
  localparam int SETTLE_CYCLES = POOL_ENTRIES + 4;
  localparam int PHASE_ITEMS = 280;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // size[19:0], handle[51:20], zero pad
  logic        s_tuser = 1'b0; // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // out_handle[31:0], out_length[51:32],
                               // cached_bytes[75:52], zero pad
  logic [2:0]  m_tuser;        // outcome

  int mismatch_count;
  int pending_results;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int free_pct = 50;

  logic [23:0] limit_steps [6] = '{24'hFFFFFF, 24'd0, 24'd20000, CACHE_LIMIT_RST,
                                   24'd300000, 24'hFFFFFF};

  always #4 clk = ~clk;

  buffer_pool_first_fit_unit #(.POOL_ENTRIES(POOL_ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  pool_result_checker #(.POOL_ENTRIES(POOL_ENTRIES)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  // Stall the result side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one request and hold it until the transfer
  task automatic send_request(input logic cmd, input logic [SIZE_W-1:0] size,
                              input logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, handle, size};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off requests until every result has been taken
  task automatic drain_results;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_cache_limit(input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 26;
        recv_idle_pct = 52;
      end
      1: begin
        send_idle_pct = 52;
        recv_idle_pct = 26;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Mostly small buffers so the pool fills and empties, a few large ones
  task automatic send_random_request;
    logic              cmd;
    logic [SIZE_W-1:0] size;
    logic [31:0]       handle;
    int                pick;
    cmd  = ($urandom_range(99) < free_pct) ? CMD_FREE : CMD_ALLOC;
    pick = $urandom_range(99);
    if (pick < 65) size = SIZE_W'($urandom_range(2047));
    else if (pick < 85) size = SIZE_W'($urandom_range(65535));
    else if (pick < 95) size = SIZE_W'($urandom);
    else size = $urandom_range(1) ? '1 : '0;
    pick = $urandom_range(99);
    if (pick < 5) handle = '0;
    else if (pick < 10) handle = '1;
    else handle = $urandom;
    send_request(cmd, size, handle);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    set_idling(0);

    // Directed: empty pool, null free, budget edges, full pool, first fit
    send_request(CMD_ALLOC, 20'd0, 32'h0);
    send_request(CMD_FREE, 20'd100, 32'h0);
    send_request(CMD_FREE, 20'd0, 32'hFFFFFFFF);
    send_request(CMD_FREE, 20'hFFFFF, 32'h1);
    send_request(CMD_FREE, 20'd1, 32'h2);
    send_request(CMD_ALLOC, 20'd0, 32'hFFFFFFFF);
    send_request(CMD_ALLOC, 20'hFFFFF, 32'h0);
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      send_request(CMD_FREE, SIZE_W'(i * 3 + 1), 32'h100 + i);
    end
    send_request(CMD_FREE, 20'd5, 32'hABC);
    send_request(CMD_ALLOC, 20'd20, 32'h0);
    send_request(CMD_ALLOC, 20'hFFFFF, 32'h0);
    send_request(CMD_ALLOC, 20'd0, 32'h0);
    drain_results();

    // Random phases: each writes its budget first, and each pair of phases shares an idling pattern
    for (int phase = 0; phase < 6; phase++) begin
      repeat (SETTLE_CYCLES) @(negedge clk);
      write_cache_limit(limit_steps[phase]);
      set_idling(phase / 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          free_pct = 30 + 20 * $urandom_range(2);
        end
        if ($urandom_range(59) == 0) begin
          drain_results();
        end
        send_random_request();
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bpff_pkg.sv
design/bpff_cell.sv
design/buffer_pool_first_fit_unit.sv
sim/pool_result_checker.sv
sim/buffer_pool_first_fit_unit_tb.sv
